>>> design/sync_length_xor_frame_deframer_top_defines.svh
// Assertion macros used by the deframer core.
`ifndef SYNC_LENGTH_XOR_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sfd_pkg.sv
// Types and constants for the sync/length/XOR frame deframer.
package sfd_pkg;

  localparam int LENGTH_BITS = 24;   // width of the length accumulator
  localparam int IDX_W       = 24;   // byte index / payload length / limit width

  localparam logic [7:0]       SYNC_HI     = 8'hAA;
  localparam logic [7:0]       SYNC_LO     = 8'h55;
  localparam logic [7:0]       SYNC_ZERO   = 8'h00;
  localparam logic [7:0]       XOR_SEED    = SYNC_ZERO ^ SYNC_HI ^ SYNC_LO;
  localparam logic [IDX_W-1:0] MAX_LEN_RST = IDX_W'(65535);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_ZERO,
    PH_LEN,
    PH_LENX,
    PH_CMD,
    PH_DATA,
    PH_END
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_OK        = 3'd1,
    KIND_CKSUM_ERR = 3'd2,
    KIND_LENX_ERR  = 3'd3,
    KIND_RANGE_ERR = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abort;
  } rx_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       frame_cmd;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic [IDX_W-1:0] payload_len;
    logic             last_byte;
  } result_t;

endpackage

>>> design/sfd_in_stage.sv
// Input request register of the deframer.
module sfd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfd_pkg::rx_item_t in_item,
  input  logic              take,      // downstream consumes the held request
  output logic              q_valid,
  output sfd_pkg::rx_item_t q_item
);
  import sfd_pkg::*;

  logic     valid_r, valid_nxt;
  rx_item_t item_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_valid ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

>>> design/sfd_core.sv
// Frame parser: parse state and one step of the deframing rules per request.
module sfd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  sfd_pkg::rx_item_t         item,
  input  logic [sfd_pkg::IDX_W-1:0] max_len,
  output logic                      res_valid,
  output sfd_pkg::result_t          res
);
  import sfd_pkg::*;

  `include "sync_length_xor_frame_deframer_top_defines.svh"

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [7:0]             chk_r, chk_nxt;
  logic [7:0]             xor_r, xor_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [7:0]             cmd_r, cmd_nxt;

  logic [LENGTH_BITS-1:0] len_less2;
  logic [IDX_W:0]         idx_inc;
  logic                   is_last;
  logic [7:0]             d;

  assign d         = item.rx_byte;
  assign len_less2 = acc_r - LENGTH_BITS'(2);
  assign idx_inc   = {1'b0, cnt_r} + (IDX_W+1)'(1);
  assign is_last   = idx_inc >= {1'b0, IDX_W'(acc_r)};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    chk_nxt   = chk_r;
    xor_nxt   = xor_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    res_valid = 1'b0;
    res       = '0;
    if (item.abort) begin
      phase_nxt = PH_HUNT;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          phase_nxt = (d == SYNC_HI) ? PH_SYNC2 : PH_HUNT;
        end
        PH_SYNC2: begin
          phase_nxt = (d == SYNC_LO) ? PH_ZERO : PH_HUNT;
        end
        PH_ZERO: begin
          if (d == SYNC_ZERO) begin
            xor_nxt   = XOR_SEED;
            chk_nxt   = '0;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LEN: begin
          acc_nxt = LENGTH_BITS'({acc_r, d});
          xor_nxt = xor_r ^ d;
          chk_nxt = chk_r ^ d;
          cnt_nxt = idx_inc[IDX_W-1:0];
          if (idx_inc >= (IDX_W+1)'(3)) begin
            cnt_nxt   = '0;
            phase_nxt = PH_LENX;
          end
        end
        PH_LENX: begin
          xor_nxt = xor_r ^ d;
          if (d == chk_r) begin
            phase_nxt = PH_CMD;
          end else begin
            phase_nxt = PH_HUNT;
            res_valid = 1'b1;
            res.kind  = KIND_LENX_ERR;
          end
        end
        PH_CMD: begin
          cmd_nxt = d;
          xor_nxt = xor_r ^ d;
          cnt_nxt = '0;
          if (acc_r < LENGTH_BITS'(2)) begin
            phase_nxt     = PH_HUNT;
            res_valid     = 1'b1;
            res.kind      = KIND_RANGE_ERR;
            res.frame_cmd = d;
          end else begin
            acc_nxt = len_less2;
            if (IDX_W'(len_less2) > max_len) begin
              phase_nxt       = PH_HUNT;
              res_valid       = 1'b1;
              res.kind        = KIND_RANGE_ERR;
              res.frame_cmd   = d;
              res.payload_len = IDX_W'(len_less2);
            end else begin
              phase_nxt = (len_less2 == '0) ? PH_END : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          xor_nxt          = xor_r ^ d;
          cnt_nxt          = idx_inc[IDX_W-1:0];
          if (is_last) begin
            phase_nxt = PH_END;
          end
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.frame_cmd    = cmd_r;
          res.payload_byte = d;
          res.byte_index   = cnt_r;
          res.payload_len  = IDX_W'(acc_r);
          res.last_byte    = is_last;
        end
        PH_END: begin
          phase_nxt       = PH_HUNT;
          res_valid       = 1'b1;
          res.kind        = (xor_r == d) ? KIND_OK : KIND_CKSUM_ERR;
          res.frame_cmd   = cmd_r;
          res.payload_len = IDX_W'(acc_r);
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else if (step_en) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      acc_r <= acc_nxt;
      chk_r <= chk_nxt;
      xor_r <= xor_nxt;
      cnt_r <= cnt_nxt;
      cmd_r <= cmd_nxt;
    end
  end

  `SFD_ASSERT_IMPL(a_payload_in_data, step_en && res_valid && res.kind == KIND_PAYLOAD, phase_r == PH_DATA, "payload result outside data phase")
  `SFD_ASSERT_NEXT(a_last_to_end, step_en && res_valid && res.kind == KIND_PAYLOAD && res.last_byte, phase_r == PH_END, "last payload byte did not lead to check byte")
  `SFD_ASSERT_NEXT(a_abort_hunt, step_en && item.abort, phase_r == PH_HUNT, "abort did not force hunt")
  `SFD_ASSERT_IMPL(a_len_count, phase_r == PH_LEN, cnt_r < IDX_W'(3), "length byte count out of range")

endmodule

>>> design/sfd_out_stage.sv
// Result register of the deframer.
module sfd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sfd_pkg::result_t res,
  output logic             space,     // a result may be loaded this cycle
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::result_t out_res
);
  import sfd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign space     = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> design/sync_length_xor_frame_deframer_top.sv
// Top level of the sync-word / length / XOR-checksum frame deframer.
//
// Received bytes arrive as requests on the in_ channel and are parsed against the
// frame layout AA 55 00 L2 L1 L0 LX CMD payload... CK, where L2..L0 is a big-endian
// length equal to payload count plus 2, LX is the XOR of the length bytes and CK
// is the XOR of every frame byte before it. Each payload byte yields one result
// (kind 0) with its index and a last flag; frame end or a framing fault yields one
// status result (1 ok, 2 checksum error, 3 length XOR error, 4 length out of range,
// meaning length below 2 or payload above the limit). Bad sync bytes and aborted
// requests return to the hunt silently. Throughput is one request per clock while
// the result register is not stalled; a request is held in the input register and
// its result, if any, is loaded into the result register when the parser takes it.
// The parser state update is the single loop that sets this rate: one byte fully
// decides the next state. in_ready drops only when both the input register and
// the result register are full and out_ready is low. The payload limit register
// (reset 65535) is written through cfg_ (cfg_ready is always high) and must only be
// changed while no frame is in flight.
module sync_length_xor_frame_deframer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  input  logic                      in_abort,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_kind,
  output logic [7:0]                out_frame_cmd,
  output logic [7:0]                out_payload_byte,
  output logic [sfd_pkg::IDX_W-1:0] out_byte_index,
  output logic [sfd_pkg::IDX_W-1:0] out_payload_len,
  output logic                      out_last_byte,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sfd_pkg::IDX_W-1:0] cfg_max_payload_len
);
  import sfd_pkg::*;

  rx_item_t         in_item;
  rx_item_t         q_item;
  logic             q_valid;
  logic             step_en;     // held request is consumed by the parser
  logic             space;       // result register can take a result
  logic             res_valid;
  result_t          res;
  result_t          out_res;
  logic [IDX_W-1:0] max_len_r;

  // Configuration: single register, no backpressure.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_payload_len;
    end
  end

  assign in_item.rx_byte = in_rx_byte;
  assign in_item.abort   = in_abort;

  // The parser steps whenever a request is held and the result register has room,
  // whether or not this byte produces a result.
  assign step_en = q_valid && space;

  sfd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step_en),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  sfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (q_item),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_frame_cmd    = out_res.frame_cmd;
  assign out_payload_byte = out_res.payload_byte;
  assign out_byte_index   = out_res.byte_index;
  assign out_payload_len  = out_res.payload_len;
  assign out_last_byte    = out_res.last_byte;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the sync/length/XOR frame deframer top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  // Cycles without any accepted request before the run is declared hung. The worst
  // legitimate quiet stretch is a long receiver stall plus a long sender gap.
  localparam int STALL_LIMIT = 5000;
  // Extra cycles to let a request that produces no result leave the pipeline.
  localparam int PIPE_CYCLES = 4;
  // Frame bytes per configuration phase of the random part.
  localparam int PHASE_BYTES = 185;
  // Declared payloads above this are cut short by an abort.
  localparam int MAX_SENT_PAYLOAD = 48;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             in_abort = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [2:0]       out_kind;
  logic [7:0]       out_frame_cmd;
  logic [7:0]       out_payload_byte;
  logic [IDX_W-1:0] out_byte_index;
  logic [IDX_W-1:0] out_payload_len;
  logic             out_last_byte;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_max_payload_len = '0;

  sync_length_xor_frame_deframer_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .in_abort            (in_abort),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_frame_cmd       (out_frame_cmd),
    .out_payload_byte    (out_payload_byte),
    .out_byte_index      (out_byte_index),
    .out_payload_len     (out_payload_len),
    .out_last_byte       (out_last_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_payload_len (cfg_max_payload_len)
  );

  // Mirror of the parser: follows every accepted request and queues the result
  // the block must produce for it, then matches results in order.
  class deframe_tracker;
    phase_t           ph;
    logic [IDX_W-1:0] len_acc;   // declared length, later the payload count
    logic [7:0]       len_xor;   // XOR of the three length bytes
    logic [7:0]       run_xor;   // XOR of all frame bytes so far
    logic [IDX_W-1:0] count;     // length byte count, later the payload index
    logic [7:0]       cmd;
    logic [IDX_W-1:0] limit;
    result_t          pending_results[$];
    int               fail_count;

    function new();
      ph         = PH_HUNT;
      len_acc    = '0;
      len_xor    = '0;
      run_xor    = '0;
      count      = '0;
      cmd        = '0;
      limit      = MAX_LEN_RST;
      fail_count = 0;
    endfunction

    function void take_byte(input logic [7:0] d, input logic ab);
      result_t r;
      bit      produced;
      r = '0;
      produced = 1'b0;
      if (ab) begin
        ph = PH_HUNT;
      end else begin
        case (ph)
          PH_HUNT: begin
            if (d == SYNC_HI) ph = PH_SYNC2;
          end
          PH_SYNC2: begin
            if (d == SYNC_LO) ph = PH_ZERO;
            else ph = PH_HUNT;
          end
          PH_ZERO: begin
            if (d == SYNC_ZERO) begin
              run_xor = XOR_SEED;
              len_xor = '0;
              len_acc = '0;
              count   = '0;
              ph      = PH_LEN;
            end else begin
              ph = PH_HUNT;
            end
          end
          PH_LEN: begin
            len_acc = {len_acc[IDX_W-9:0], d};
            run_xor ^= d;
            len_xor ^= d;
            count   = count + 1'b1;
            if (count >= 3) begin
              count = '0;
              ph    = PH_LENX;
            end
          end
          PH_LENX: begin
            run_xor ^= d;
            if (d == len_xor) begin
              ph = PH_CMD;
            end else begin
              ph       = PH_HUNT;
              r.kind   = KIND_LENX_ERR;
              produced = 1'b1;
            end
          end
          PH_CMD: begin
            cmd = d;
            run_xor ^= d;
            count = '0;
            if (len_acc < 2) begin
              // too short to hold even the command and check bytes
              ph          = PH_HUNT;
              r.kind      = KIND_RANGE_ERR;
              r.frame_cmd = d;
              produced    = 1'b1;
            end else begin
              len_acc = len_acc - 2'd2;
              if (len_acc > limit) begin
                ph            = PH_HUNT;
                r.kind        = KIND_RANGE_ERR;
                r.frame_cmd   = d;
                r.payload_len = len_acc;
                produced      = 1'b1;
              end else if (len_acc == 0) begin
                ph = PH_END;   // empty payload: check byte comes next
              end else begin
                ph = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            r.kind         = KIND_PAYLOAD;
            r.frame_cmd    = cmd;
            r.payload_byte = d;
            r.byte_index   = count;
            r.payload_len  = len_acc;
            r.last_byte    = ({1'b0, count} + 25'd1) >= {1'b0, len_acc};
            produced       = 1'b1;
            run_xor ^= d;
            count = count + 1'b1;
            if (r.last_byte) ph = PH_END;
          end
          default: begin
            ph            = PH_HUNT;
            r.kind        = (run_xor == d) ? KIND_OK : KIND_CKSUM_ERR;
            r.frame_cmd   = cmd;
            r.payload_len = len_acc;
            produced      = 1'b1;
          end
        endcase
      end
      if (produced) pending_results.push_back(r);
    endfunction

    function void cmp(input string name, input logic [23:0] want_v, input logic [23:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want_v, got_v);
        fail_count++;
      end
    endfunction

    function void match_result(input logic [2:0] kind, input logic [7:0] fcmd,
                               input logic [7:0] pbyte, input logic [IDX_W-1:0] bidx,
                               input logic [IDX_W-1:0] plen, input logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: kind %0h cmd %0h byte %0h index %0h len %0h",
                 $time, kind, fcmd, pbyte, bidx, plen);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      cmp("kind", 24'(want.kind), 24'(kind));
      cmp("frame_cmd", 24'(want.frame_cmd), 24'(fcmd));
      cmp("payload_byte", 24'(want.payload_byte), 24'(pbyte));
      cmp("byte_index", want.byte_index, bidx);
      cmp("payload_len", want.payload_len, plen);
      cmp("last_byte", 24'(want.last_byte), 24'(last));
    endfunction
  endclass

  deframe_tracker sb;
  bit             quiet = 1'b0;   // when set neither side starts a new gap or stall
  int             stall_left = 0;
  int             idle_cycles = 0;
  int             items_sent = 0;
  logic [7:0]     frame_bytes[$];

  initial begin
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (quiet || $urandom_range(0, 99) < 70) return 0;
    return pick_gap();
  endfunction

  // Payload content, biased toward the sync values and the extremes.
  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 19))
      0:       return SYNC_HI;
      1:       return SYNC_LO;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: random back-pressure on the result channel.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  // Every accepted result is matched against the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.match_result(out_kind, out_frame_cmd, out_payload_byte, out_byte_index,
                      out_payload_len, out_last_byte);
    end
  end

  // Hang detection: any accepted request on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t no request accepted for %0d cycles", $time, STALL_LIMIT);
      $display("[sync_length_xor_frame_deframer_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One byte request. Valid is left high on return so back-to-back requests keep
  // it asserted; settle() drops it.
  task automatic push(input logic [7:0] b, input logic ab);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_abort   <= ab;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_byte(b, ab);
    items_sent++;
  endtask

  // Stop sending, wait for every pending result, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // Limit writes only happen with the block idle and the parser hunting; an abort
  // first closes any frame left open by a truncated one.
  task automatic write_limit(input logic [IDX_W-1:0] v);
    push(8'h00, 1'b1);
    settle();
    cfg_valid           <= 1'b1;
    cfg_max_payload_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.limit = v;
    cfg_valid <= 1'b0;
  endtask

  // AA 55 00 L2 L1 L0 LX CMD payload CK; the flips corrupt LX or CK.
  function automatic void build_frame(input logic [23:0] decl, input logic [7:0] fcmd,
                                      input int n_data, input logic [7:0] lx_flip,
                                      input logic [7:0] ck_flip, input bit with_ck);
    logic [7:0] ck;
    frame_bytes = '{SYNC_HI, SYNC_LO, SYNC_ZERO, decl[23:16], decl[15:8], decl[7:0]};
    frame_bytes.push_back(decl[23:16] ^ decl[15:8] ^ decl[7:0] ^ lx_flip);
    frame_bytes.push_back(fcmd);
    for (int i = 0; i < n_data; i++) frame_bytes.push_back(data_byte());
    ck = ck_flip;
    foreach (frame_bytes[i]) ck ^= frame_bytes[i];
    if (with_ck) frame_bytes.push_back(ck);
  endfunction

  // Sends the built frame; an abort request replaces byte abort_at (may be one past
  // the end), a negative value means no abort.
  task automatic send_frame(input int abort_at);
    for (int i = 0; i <= frame_bytes.size(); i++) begin
      if (i == abort_at) begin
        push(8'($urandom_range(0, 255)), 1'b1);
        break;
      end
      if (i < frame_bytes.size()) push(frame_bytes[i], 1'b0);
    end
  endtask

  // Junk between frames: random bytes or a sync that breaks off.
  task automatic send_noise();
    int n;
    case ($urandom_range(0, 2))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) push(8'($urandom_range(0, 255)), 1'b0);
      end
      1: begin
        push(SYNC_HI, 1'b0);
        push(8'($urandom_range(0, 255)) ^ SYNC_LO ^ 8'($urandom_range(1, 255)), 1'b0);
      end
      default: begin
        push(SYNC_HI, 1'b0);
        push(SYNC_LO, 1'b0);
        push(8'($urandom_range(1, 255)), 1'b0);
      end
    endcase
    if ($urandom_range(0, 1) == 1) push(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // One well-formed or deliberately broken frame, sized around the current limit.
  task automatic random_frame();
    logic [23:0] plen;
    logic [23:0] decl;
    logic [7:0]  lx_flip;
    logic [7:0]  ck_flip;
    int          r;
    int          v;
    int          n_data;
    int          abort_at;
    bit          in_range;
    bit          cut_short;
    r = $urandom_range(0, 99);
    if (r < 55) plen = 24'($urandom_range(0, 6));
    else if (r < 75) plen = 24'($urandom_range(7, 40));
    else if (r < 85 && sb.limit <= 40) plen = sb.limit;      // exactly at the limit
    else if (r < 92) plen = sb.limit + 1'b1;                // one over the limit
    else plen = 24'($urandom);
    decl = plen + 24'd2;
    if ($urandom_range(0, 19) == 0) decl = 24'($urandom_range(0, 1));  // below 2
    in_range  = (decl >= 2) && ((decl - 24'd2) <= sb.limit);
    n_data    = in_range ? int'(decl - 24'd2) : 0;
    cut_short = in_range && (n_data > MAX_SENT_PAYLOAD);
    if (cut_short) n_data = $urandom_range(0, 12);
    v = $urandom_range(0, 99);
    lx_flip = (v >= 80 && v < 88) ? 8'($urandom_range(1, 255)) : 8'h00;
    ck_flip = (v >= 70 && v < 80) ? 8'($urandom_range(1, 255)) : 8'h00;
    build_frame(decl, 8'($urandom_range(0, 255)), n_data, lx_flip, ck_flip,
                in_range && !cut_short);
    abort_at = -1;
    if (cut_short) abort_at = frame_bytes.size();
    else if (v >= 88 && v < 95) abort_at = $urandom_range(0, frame_bytes.size() - 1);
    else if (v >= 95) begin
      // truncated frame, left for whatever follows to run into
      r = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > r) void'(frame_bytes.pop_back());
    end
    send_frame(abort_at);
  endtask

  initial begin
    logic [IDX_W-1:0] limits[5];
    int               phase_start;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty payload frame, both bad sync bytes, abort mid-sync,
    // length below 2 (stops at the command byte), all at the reset limit.
    build_frame(24'd2, 8'h81, 0, 8'h00, 8'h00, 1'b1);
    send_frame(-1);
    push(SYNC_HI, 1'b0);
    push(8'h00, 1'b0);
    push(SYNC_HI, 1'b0);
    push(SYNC_LO, 1'b0);
    push(8'h01, 1'b0);
    build_frame(24'd2, 8'h00, 0, 8'h00, 8'h00, 1'b1);
    send_frame(2);
    build_frame(24'd1, 8'hFF, 0, 8'h00, 8'h00, 1'b0);
    send_frame(-1);

    // Random frames under several limits, extremes included. Each write first
    // holds the sender until every pending result is back.
    limits = '{24'd0, 24'd16777213, 24'd5, 24'($urandom_range(6, 48)), MAX_LEN_RST};
    foreach (limits[p]) begin
      write_limit(limits[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 7) == 0) quiet = !quiet;
        if ($urandom_range(0, 3) == 0) send_noise();
        random_frame();
      end
    end

    settle();
    if (sb.fail_count == 0) begin
      $display("[sync_length_xor_frame_deframer_top] OK");
    end else begin
      $display("[sync_length_xor_frame_deframer_top] ERROR");
    end
    $finish;
  end
endmodule
